### hw/rtl/lcsc_pkg.sv
// ----------------------------------------------------------------------------
// lcsc_pkg
// Shared types and constants for the LED chaser with speed control.
// ----------------------------------------------------------------------------
package lcsc_pkg;

    // Width of the period, tick count and limit registers
    localparam int PERIOD_W = 13;

    // LED drive width
    localparam int PATTERN_W = 8;

    // Reset values
    localparam logic [PERIOD_W-1:0] MIN_PERIOD_RESET  = 13'd32;
    localparam logic [PERIOD_W-1:0] MAX_PERIOD_RESET  = 13'd1024;
    localparam logic [PERIOD_W-1:0] STEP_PERIOD_RESET = 13'd1024;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_MIN_PERIOD = 1'b0,
        REG_MAX_PERIOD = 1'b1
    } cfg_index_t;

    // Input beat: one tick with both button levels
    typedef struct packed {
        logic a_pressed;
        logic b_pressed;
    } in_beat_t;

    // Result beat: LED drive and direction after the tick
    typedef struct packed {
        logic [PATTERN_W-1:0] led_pattern;
        logic                 going_up;
    } out_beat_t;

    // Period limits as held by the configuration registers
    typedef struct packed {
        logic [PERIOD_W-1:0] min_period;
        logic [PERIOD_W-1:0] max_period;
    } period_cfg_t;

endpackage

### hw/rtl/lcsc_cfg.sv
// ----------------------------------------------------------------------------
// lcsc_cfg
// Configuration registers holding the step period limits.
// ----------------------------------------------------------------------------
module lcsc_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  lcsc_pkg::cfg_index_t          cfg_index,
    input  logic [lcsc_pkg::PERIOD_W-1:0] cfg_wdata,
    output lcsc_pkg::period_cfg_t         period_cfg
);
    import lcsc_pkg::*;

    logic [PERIOD_W-1:0] min_period_reg;
    logic [PERIOD_W-1:0] max_period_reg;

    // Write the addressed limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_period_reg <= MIN_PERIOD_RESET;
            max_period_reg <= MAX_PERIOD_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MIN_PERIOD: begin
                    min_period_reg <= cfg_wdata;
                end
                REG_MAX_PERIOD: begin
                    max_period_reg <= cfg_wdata;
                end
                default: begin
                    min_period_reg <= min_period_reg;
                end
            endcase
        end
    end

    assign period_cfg.min_period = min_period_reg;
    assign period_cfg.max_period = max_period_reg;

endmodule

### hw/rtl/lcsc_step.sv
// ----------------------------------------------------------------------------
// lcsc_step
// Chaser state and its one-tick update: edge detect, period halve/double
// with clamp and reversal, tick count and position step.
// ----------------------------------------------------------------------------
module lcsc_step #(
    parameter int LED_COUNT = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  tick_en,
    input  lcsc_pkg::in_beat_t    tick_beat,
    input  lcsc_pkg::period_cfg_t period_cfg,
    output lcsc_pkg::out_beat_t   result_next
);
    import lcsc_pkg::*;

    localparam int POS_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LED_COUNT - 1);

    logic [POS_W-1:0]    position_reg;
    logic [POS_W-1:0]    position_next;
    logic                direction_up_reg;
    logic                direction_up_next;
    logic [PERIOD_W-1:0] step_period_reg;
    logic [PERIOD_W-1:0] step_period_next;
    logic [PERIOD_W-1:0] tick_count_reg;
    logic [PERIOD_W-1:0] tick_count_next;
    logic                a_previous_reg;
    logic                b_previous_reg;

    logic                a_rise;
    logic                b_rise;
    logic [PERIOD_W-1:0] halved;
    logic [PERIOD_W:0]   doubled;
    logic [PERIOD_W-1:0] tick_inc;

    assign a_rise  = tick_beat.a_pressed & ~a_previous_reg;
    assign b_rise  = tick_beat.b_pressed & ~b_previous_reg;
    assign halved  = {1'b0, step_period_reg[PERIOD_W-1:1]};
    assign doubled = {step_period_reg, 1'b0};
    assign tick_inc = tick_count_reg + 1'b1;

    // Adjust the period on a button edge; A takes priority over B
    always_comb begin
        step_period_next  = step_period_reg;
        direction_up_next = direction_up_reg;
        if (a_rise) begin
            if (halved < period_cfg.min_period) begin
                step_period_next  = period_cfg.min_period;
                direction_up_next = ~direction_up_reg;
            end else begin
                step_period_next = halved;
            end
        end else if (b_rise) begin
            if (doubled > {1'b0, period_cfg.max_period}) begin
                step_period_next  = period_cfg.max_period;
                direction_up_next = ~direction_up_reg;
            end else begin
                step_period_next = doubled[PERIOD_W-1:0];
            end
        end
    end

    // Advance the tick count and step the position when it reaches the period
    always_comb begin
        tick_count_next = tick_inc;
        position_next   = position_reg;
        if (tick_inc >= step_period_next) begin
            tick_count_next = '0;
            if (direction_up_next) begin
                position_next = (position_reg == POS_LAST) ? '0 : position_reg + 1'b1;
            end else begin
                position_next = (position_reg == '0) ? POS_LAST : position_reg - 1'b1;
            end
        end
    end

    // Drive the LED pattern from the new position; positions past the drive stay dark
    always_comb begin
        if (int'(position_next) < PATTERN_W) begin
            result_next.led_pattern = PATTERN_W'(1) << position_next;
        end else begin
            result_next.led_pattern = '0;
        end
        result_next.going_up = direction_up_next;
    end

    // Commit the state on each tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg     <= '0;
            direction_up_reg <= 1'b1;
            step_period_reg  <= STEP_PERIOD_RESET;
            tick_count_reg   <= '0;
            a_previous_reg   <= 1'b0;
            b_previous_reg   <= 1'b0;
        end else if (tick_en) begin
            position_reg     <= position_next;
            direction_up_reg <= direction_up_next;
            step_period_reg  <= step_period_next;
            tick_count_reg   <= tick_count_next;
            a_previous_reg   <= tick_beat.a_pressed;
            b_previous_reg   <= tick_beat.b_pressed;
        end
    end

endmodule

### hw/rtl/led_chaser_speed_control.sv
// ----------------------------------------------------------------------------
// led_chaser_speed_control
// Top level: input beat register, chaser update, result register.
// ----------------------------------------------------------------------------
// Each input beat is one timer tick carrying the levels of buttons A and B;
// every tick returns exactly one result beat with the LED pattern and the
// direction after that tick. The block takes one beat per clock cycle when
// the result side keeps up: the beat is captured in an input register, the
// chaser state updates in the cycle it leaves that register, and the result
// lands in an output register, where the result beat is held until taken.
// Throughput is set by the state update loop.
// The user must write period limits through the configuration port only
// while no tick is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module led_chaser_speed_control #(
    parameter int LED_COUNT = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  lcsc_pkg::in_beat_t            s_data,

    output logic                          m_valid,
    input  logic                          m_ready,
    output lcsc_pkg::out_beat_t           m_data,

    input  logic                          cfg_wr_en,
    input  lcsc_pkg::cfg_index_t          cfg_index,
    input  logic [lcsc_pkg::PERIOD_W-1:0] cfg_wdata
);
    import lcsc_pkg::*;

    logic        in_valid_reg;
    in_beat_t    in_beat_reg;
    logic        out_valid_reg;
    out_beat_t   out_beat_reg;
    out_beat_t   result_next;
    period_cfg_t period_cfg;
    logic        advance;

    // Move the held tick into the result register when that register frees up
    assign advance = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | advance;

    lcsc_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .period_cfg (period_cfg)
    );

    lcsc_step #(
        .LED_COUNT (LED_COUNT)
    ) u_step (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_en     (advance),
        .tick_beat   (in_beat_reg),
        .period_cfg  (period_cfg),
        .result_next (result_next)
    );

    // Hold the input beat until it advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_beat_reg <= s_data;
        end
    end

    // Hold the result beat until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_beat_reg <= result_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_beat_reg;

endmodule

### tb/tb_led_chaser_speed_control.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_chaser_speed_control
// Self-checking bench for the LED chaser with speed control.
// ----------------------------------------------------------------------------
// Each tick beat is run through a local model of the chaser (period halving
// and doubling on button edges, clamping with reversal, stepping and wrap).
// The model's result is queued, and every result beat from the block is
// compared with the oldest queued entry. A directed table covers reset,
// simultaneous edges, clamping, zero period and inverted or extreme limits.
// Random button sequences then run under several limit settings, with bursty
// input traffic and a stalling result side.
// ----------------------------------------------------------------------------
module tb_led_chaser_speed_control;
    import lcsc_pkg::*;

    localparam int LEDS        = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 8;
    localparam int PHASE_TICKS = 60;

    // Limit settings for the random phases: extremes, zero, inverted, reset
    localparam logic [PERIOD_W-1:0] PHASE_MIN [PHASES] =
        '{13'd1, 13'd1, 13'd0, 13'd3, 13'd4096, 13'd1, 13'd8191, 13'd32};
    localparam logic [PERIOD_W-1:0] PHASE_MAX [PHASES] =
        '{13'd1, 13'd8, 13'd4, 13'd64, 13'd1, 13'd8191, 13'd8191, 13'd1024};

    typedef enum logic [0:0] {
        ROW_TICK  = 1'b0,
        ROW_WRITE = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        in_beat_t            beat;
        cfg_index_t          idx;
        logic [PERIOD_W-1:0] val;
        logic                typed;
        out_beat_t           want;
    } plan_row_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_beat_t            s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    out_beat_t           m_data;
    logic                cfg_wr_en = 1'b0;
    cfg_index_t          cfg_index = REG_MIN_PERIOD;
    logic [PERIOD_W-1:0] cfg_wdata = '0;

    // Chaser model state and limits
    logic [2:0]          pos;
    logic                dir_up;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] ticks;
    logic                a_last;
    logic                b_last;
    logic [PERIOD_W-1:0] lim_lo;
    logic [PERIOD_W-1:0] lim_hi;

    out_beat_t led_expected [$];
    plan_row_t plan [$];

    int errors      = 0;
    int checked     = 0;
    int ticks_sent  = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int ready_mode  = 0;
    int ready_left  = 0;

    led_chaser_speed_control #(
        .LED_COUNT(LEDS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Advance the chaser model by one tick and return the LED drive after it
    function automatic out_beat_t chaser_step(in_beat_t beat);
        logic [PERIOD_W:0] nxt;
        out_beat_t         res;
        if (beat.a_pressed && !a_last) begin
            nxt = {1'b0, period} >> 1;
            if (nxt < {1'b0, lim_lo}) begin
                nxt    = {1'b0, lim_lo};
                dir_up = ~dir_up;
            end
            period = nxt[PERIOD_W-1:0];
        end else if (beat.b_pressed && !b_last) begin
            nxt = {period, 1'b0};
            if (nxt > {1'b0, lim_hi}) begin
                nxt    = {1'b0, lim_hi};
                dir_up = ~dir_up;
            end
            period = nxt[PERIOD_W-1:0];
        end
        a_last = beat.a_pressed;
        b_last = beat.b_pressed;
        ticks  = ticks + 1'b1;
        if (ticks >= period) begin
            ticks = '0;
            if (dir_up) begin
                pos = (pos == LEDS - 1) ? 3'd0 : pos + 3'd1;
            end else begin
                pos = (pos == 0) ? 3'(LEDS - 1) : pos - 3'd1;
            end
        end
        res.led_pattern = 8'd1 << pos;
        res.going_up    = dir_up;
        return res;
    endfunction

    function automatic plan_row_t tick_row(logic a, logic b);
        plan_row_t r;
        r = '0;
        r.kind = ROW_TICK;
        r.beat = '{a_pressed: a, b_pressed: b};
        return r;
    endfunction

    function automatic plan_row_t typed_row(logic a, logic b, logic [7:0] led, logic up);
        plan_row_t r;
        r = tick_row(a, b);
        r.typed = 1'b1;
        r.want  = '{led_pattern: led, going_up: up};
        return r;
    endfunction

    function automatic plan_row_t write_row(cfg_index_t idx, logic [PERIOD_W-1:0] val);
        plan_row_t r;
        r = '0;
        r.kind = ROW_WRITE;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        errors++;
    endtask

    // Present one tick beat, hold it until accepted, then queue its result
    task automatic send_tick(input in_beat_t beat, input logic typed, input out_beat_t want);
        int        gap;
        out_beat_t pred;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        pred = chaser_step(beat);
        led_expected.push_back(typed ? want : pred);
        ticks_sent++;
    endtask

    // Drop valid and wait until every queued result has come back
    task automatic wait_drained();
        s_valid    <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (led_expected.size() != 0);
    endtask

    task automatic write_limit(input cfg_index_t idx, input logic [PERIOD_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_MIN_PERIOD) begin
            lim_lo = val;
        end else begin
            lim_hi = val;
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Check result beats; stall the result side on its own pattern
    always @(posedge aclk) begin : result_side
        out_beat_t want;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end else begin
            cycle_count++;
            if (aresetn && m_valid && m_ready) begin
                if (led_expected.size() == 0) begin
                    report_mismatch($sformatf("result beat %h with nothing expected", m_data));
                end else begin
                    want = led_expected.pop_front();
                    checked++;
                    if (m_data.led_pattern !== want.led_pattern) begin
                        report_mismatch($sformatf("led_pattern got %h want %h",
                                                  m_data.led_pattern, want.led_pattern));
                    end
                    if (m_data.going_up !== want.going_up) begin
                        report_mismatch($sformatf("going_up got %b want %b",
                                                  m_data.going_up, want.going_up));
                    end
                end
            end
            if (ready_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                ready_left = $urandom_range(8, 64);
            end
            ready_left--;
            case (ready_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 4) != 0);
                end
            endcase
        end
    end

    initial begin : stimulus
        in_beat_t beat;
        logic     a_lvl;
        logic     b_lvl;
        int       a_hold;
        int       b_hold;
        a_lvl  = 1'b0;
        b_lvl  = 1'b0;
        a_hold = 0;
        b_hold = 0;

        // Model state after reset
        pos    = '0;
        dir_up = 1'b1;
        period = STEP_PERIOD_RESET;
        ticks  = '0;
        a_last = 1'b0;
        b_last = 1'b0;
        lim_lo = MIN_PERIOD_RESET;
        lim_hi = MAX_PERIOD_RESET;

        plan = '{
            // From reset: period 1024, nothing moves yet
            typed_row(1'b0, 1'b0, 8'h01, 1'b1),
            // Both edges at once: only A acts
            typed_row(1'b1, 1'b1, 8'h01, 1'b1),
            tick_row(1'b1, 1'b1),
            tick_row(1'b0, 1'b0),
            tick_row(1'b0, 1'b1),
            tick_row(1'b0, 1'b0),
            // Doubling past the maximum clamps and reverses
            typed_row(1'b0, 1'b1, 8'h01, 1'b0),
            // Zero minimum lets the period reach zero: step on every tick
            write_row(REG_MIN_PERIOD, 13'd0),
            write_row(REG_MAX_PERIOD, 13'd2),
            tick_row(1'b0, 1'b0),
            tick_row(1'b0, 1'b1),
            tick_row(1'b1, 1'b0),
            tick_row(1'b0, 1'b0),
            tick_row(1'b1, 1'b0),
            tick_row(1'b0, 1'b0),
            tick_row(1'b1, 1'b1),
            tick_row(1'b0, 1'b0),
            tick_row(1'b0, 1'b0),
            // Inverted limits: each test against its own limit
            write_row(REG_MIN_PERIOD, 13'd5),
            write_row(REG_MAX_PERIOD, 13'd3),
            tick_row(1'b1, 1'b0),
            tick_row(1'b0, 1'b1),
            tick_row(1'b1, 1'b0),
            tick_row(1'b0, 1'b0),
            tick_row(1'b0, 1'b0),
            // Largest limits
            write_row(REG_MIN_PERIOD, 13'd8191),
            write_row(REG_MAX_PERIOD, 13'd8191),
            tick_row(1'b1, 1'b0),
            tick_row(1'b0, 1'b1)
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                wait_drained();
                write_limit(plan[i].idx, plan[i].val);
            end else begin
                send_tick(plan[i].beat, plan[i].typed, plan[i].want);
            end
        end

        // Random button press sequences under each limit setting
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            write_limit(REG_MIN_PERIOD, PHASE_MIN[ph]);
            write_limit(REG_MAX_PERIOD, PHASE_MAX[ph]);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (a_hold == 0) begin
                    a_lvl  = ~a_lvl;
                    a_hold = $urandom_range(1, 6);
                end
                if (b_hold == 0) begin
                    b_lvl  = ~b_lvl;
                    b_hold = $urandom_range(1, 6);
                end
                a_hold--;
                b_hold--;
                if ($urandom_range(0, 9) == 0) begin
                    beat = in_beat_t'(2'($urandom_range(0, 3)));
                end else begin
                    beat = '{a_pressed: a_lvl, b_pressed: b_lvl};
                end
                send_tick(beat, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);

        $display("ran %0d ticks: directed table plus %0d limit settings", ticks_sent, PHASES);
        $display("compared %0d result beats, %0d mismatches", checked, errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### led_chaser_speed_control.f
hw/rtl/lcsc_pkg.sv
hw/rtl/lcsc_cfg.sv
hw/rtl/lcsc_step.sv
hw/rtl/led_chaser_speed_control.sv
tb/tb_led_chaser_speed_control.sv
